FILE: hdl/miu_pkg.sv
// Package for the MIPS32 integer execute unit: operation codes, status codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none
package miu_pkg;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_SUB = 6'd2, OP_SUBU = 6'd3,
        OP_AND = 6'd4, OP_OR = 6'd5, OP_XOR = 6'd6, OP_NOR = 6'd7,
        OP_SRLV = 6'd8, OP_SLLV = 6'd9, OP_SRAV = 6'd10, OP_SLT = 6'd11,
        OP_SLTU = 6'd12, OP_ADDI = 6'd13, OP_ADDIU = 6'd14, OP_ANDI = 6'd15,
        OP_ORI = 6'd16, OP_NORI = 6'd17, OP_XORI = 6'd18, OP_SRL = 6'd19,
        OP_SLL = 6'd20, OP_SRA = 6'd21, OP_SLTI = 6'd22, OP_SLTIU = 6'd23,
        OP_BEQ = 6'd24, OP_BNE = 6'd25, OP_LUI = 6'd26, OP_JR = 6'd27,
        OP_JALR = 6'd28, OP_MFHI = 6'd29, OP_MFLO = 6'd30, OP_MTHI = 6'd31,
        OP_MTLO = 6'd32, OP_MULT = 6'd33, OP_MULTU = 6'd34, OP_DIV = 6'd35,
        OP_DIVU = 6'd36, OP_J = 6'd37, OP_JAL = 6'd38, OP_SYSCALL = 6'd39,
        OP_NOP = 6'd40
    } op_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OVERFLOW = 2'd1, ST_SYSCALL = 2'd2, ST_DIV_ZERO = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_DONE, S_OUT
    } state_t;

    localparam logic [31:0] REGION_MASK = 32'hF000_0000;
    localparam logic [4:0]  LINK_REG    = 5'd31;
    localparam int          LUI_SHIFT   = 16;
    localparam int          DIV_STEPS   = 32;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch input beat
        logic exec;       // run the combinational ops and start mult/div
        logic mul_fin;    // take the multiplier product into HI/LO
        logic div_step;   // one restoring division step
        logic div_fin;    // fix signs, write HI/LO
        logic commit;     // write register file and pc, load output register
        logic out_take;   // output register drained
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_last;
    } stat_t;

endpackage
`default_nettype wire

FILE: hdl/miu_ctrl.sv
// Controller state machine of the execute unit.
// Depends on miu_pkg for the state enum and command/status structs.
`default_nettype none
module miu_ctrl
    import miu_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_beat,
    input  wire logic  out_beat,
    input  wire stat_t st,
    output cmd_t       cmd,
    output logic       in_ready,
    output logic       out_valid
);
    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_beat) begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ: state_next = S_EXEC;
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (st.is_mul)      state_next = S_MUL;
                else if (st.is_div) state_next = S_DIV;
                else                state_next = S_DONE;
            end
            S_MUL: begin
                cmd.mul_fin = 1'b1;
                state_next  = S_DONE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) state_next = S_DONE;
            end
            S_DONE: begin
                cmd.div_fin = st.is_div;
                cmd.commit  = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                out_valid = 1'b1;
                if (out_beat) begin
                    cmd.out_take = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/miu_dp.sv
// Datapath of the execute unit: register file, HI/LO, pc, ALU, multiplier
// and radix-2 divider. Depends on miu_pkg.
`default_nettype none
module miu_dp
    import miu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    output stat_t            st,
    input  wire logic        cfg_beat,
    input  wire logic [31:0] cfg_data,
    input  wire logic [5:0]  in_mode,
    input  wire logic [4:0]  in_rs,
    input  wire logic [4:0]  in_rt,
    input  wire logic [4:0]  in_rd,
    input  wire logic [15:0] in_imm,
    input  wire logic [4:0]  in_shamt,
    input  wire logic [25:0] in_target,
    output logic [1:0]       out_status,
    output logic [31:0]      out_next_pc,
    output logic             out_we,
    output logic [4:0]       out_widx,
    output logic [31:0]      out_wval
);
    logic [31:0] text_base_reg, pc_reg, hi_reg, lo_reg;
    logic [31:0] rf_reg [32];
    logic [5:0]  mode_reg;
    logic [4:0]  rs_i_reg, rt_i_reg, rd_i_reg, shamt_reg;
    logic [15:0] imm_reg;
    logic [25:0] target_reg;
    logic [31:0] rs_reg, rt_reg;
    logic [1:0]  status_reg;
    logic [31:0] npc_reg, wval_reg;
    logic        we_reg;
    logic [4:0]  widx_reg;
    logic [63:0] prod_reg;
    logic [31:0] quo_reg, rem_reg, divisor_reg;
    logic [5:0]  cnt_reg;
    logic        neg_q_reg, neg_r_reg;

    // config and pc; a text_base write leaves the running pc alone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_base_reg <= 32'h0040_0000;
            pc_reg        <= 32'h0040_0000;
        end else begin
            if (cfg_beat) begin
                text_base_reg <= cfg_data;
            end
            if (cmd.commit) begin
                pc_reg <= npc_reg;
            end
        end
    end

    // latch input beat
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= in_mode;
            rs_i_reg   <= in_rs;
            rt_i_reg   <= in_rt;
            rd_i_reg   <= in_rd;
            imm_reg    <= in_imm;
            shamt_reg  <= in_shamt;
            target_reg <= in_target;
        end
    end

    // register file read, register zero reads zero
    always_ff @(posedge aclk) begin
        rs_reg <= (rs_i_reg == '0) ? '0 : rf_reg[rs_i_reg];
        rt_reg <= (rt_i_reg == '0) ? '0 : rf_reg[rt_i_reg];
    end

    // register file write; reset clears all entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) rf_reg[i] <= '0;
        end else if (cmd.commit && we_reg) begin
            rf_reg[widx_reg] <= wval_reg;
        end
    end

    // combinational execute
    logic [31:0] imm_s, imm_z, pc4, sum, diff, addi_sum, r;
    logic [31:0] b_off;
    logic        ovf, we, tk;
    logic [4:0]  widx;
    logic [1:0]  status;
    logic [31:0] npc;
    always_comb begin
        imm_z    = {16'h0, imm_reg};
        imm_s    = {{16{imm_reg[15]}}, imm_reg};
        pc4      = pc_reg + 32'd4;
        b_off    = {imm_s[29:0], 2'b00};
        sum      = rs_reg + rt_reg;
        diff     = rs_reg - rt_reg;
        addi_sum = rs_reg + imm_s;
        r        = '0;
        we       = 1'b0;
        widx     = rd_i_reg;
        status   = ST_OK;
        npc      = pc4;
        ovf      = 1'b0;
        tk       = 1'b0;
        case (mode_reg)
            OP_ADD: begin
                ovf = ~(rs_reg[31] ^ rt_reg[31]) & (rs_reg[31] ^ sum[31]);
                r = sum; we = ~ovf;
            end
            OP_SUB: begin
                ovf = (rs_reg[31] ^ rt_reg[31]) & (rs_reg[31] ^ diff[31]);
                r = diff; we = ~ovf;
            end
            OP_ADDI: begin
                ovf = ~(rs_reg[31] ^ imm_s[31]) & (rs_reg[31] ^ addi_sum[31]);
                r = addi_sum; we = ~ovf; widx = rt_i_reg;
            end
            OP_ADDU: begin r = sum; we = 1'b1; end
            OP_SUBU: begin r = diff; we = 1'b1; end
            OP_AND:  begin r = rs_reg & rt_reg; we = 1'b1; end
            OP_OR:   begin r = rs_reg | rt_reg; we = 1'b1; end
            OP_XOR:  begin r = rs_reg ^ rt_reg; we = 1'b1; end
            OP_NOR:  begin r = ~(rs_reg | rt_reg); we = 1'b1; end
            OP_SRLV: begin r = rt_reg >> rs_reg[4:0]; we = 1'b1; end
            OP_SLLV: begin r = rt_reg << rs_reg[4:0]; we = 1'b1; end
            OP_SRAV: begin r = $unsigned($signed(rt_reg) >>> rs_reg[4:0]); we = 1'b1; end
            OP_SLT:  begin r = {31'h0, $signed(rs_reg) < $signed(rt_reg)}; we = 1'b1; end
            OP_SLTU: begin r = {31'h0, rs_reg < rt_reg}; we = 1'b1; end
            OP_ADDIU: begin r = addi_sum; we = 1'b1; widx = rt_i_reg; end
            OP_ANDI: begin r = rs_reg & imm_z; we = 1'b1; widx = rt_i_reg; end
            OP_ORI:  begin r = rs_reg | imm_z; we = 1'b1; widx = rt_i_reg; end
            OP_NORI: begin r = ~(rs_reg | imm_z); we = 1'b1; widx = rt_i_reg; end
            OP_XORI: begin r = rs_reg ^ imm_z; we = 1'b1; widx = rt_i_reg; end
            OP_SRL:  begin r = rt_reg >> shamt_reg; we = 1'b1; end
            OP_SLL:  begin r = rt_reg << shamt_reg; we = 1'b1; end
            OP_SRA:  begin r = $unsigned($signed(rt_reg) >>> shamt_reg); we = 1'b1; end
            OP_SLTI: begin
                r = {31'h0, $signed(rs_reg) < $signed(imm_s)}; we = 1'b1; widx = rt_i_reg;
            end
            OP_SLTIU: begin r = {31'h0, rs_reg < imm_s}; we = 1'b1; widx = rt_i_reg; end
            OP_BEQ: begin tk = (rs_reg == rt_reg); if (tk) npc = pc4 + b_off; end
            OP_BNE: begin tk = (rs_reg != rt_reg); if (tk) npc = pc4 + b_off; end
            OP_LUI: begin r = imm_z << LUI_SHIFT; we = 1'b1; widx = rt_i_reg; end
            OP_JR:   npc = rs_reg;
            OP_JALR: begin r = pc4; we = 1'b1; npc = rs_reg; end
            OP_MFHI: begin r = hi_reg; we = 1'b1; end
            OP_MFLO: begin r = lo_reg; we = 1'b1; end
            OP_DIV, OP_DIVU: if (rt_reg == '0) status = ST_DIV_ZERO;
            OP_J:   npc = (pc4 & REGION_MASK) | {4'h0, target_reg, 2'b00};
            OP_JAL: begin
                r = pc4; we = 1'b1; widx = LINK_REG;
                npc = (pc4 & REGION_MASK) | {4'h0, target_reg, 2'b00};
            end
            OP_SYSCALL: status = ST_SYSCALL;
            default: ;
        endcase
        if (ovf) status = ST_OVERFLOW;
        if (widx == '0) we = 1'b0;
    end

    assign st.is_mul   = (mode_reg == OP_MULT) || (mode_reg == OP_MULTU);
    assign st.is_div   = ((mode_reg == OP_DIV) || (mode_reg == OP_DIVU)) && (rt_reg != '0);
    assign st.div_last = (cnt_reg == 6'(DIV_STEPS - 1));

    // multiplier: 33x33 signed product, registered
    logic signed [32:0] ma, mb;
    assign ma = {(mode_reg == OP_MULT) & rs_reg[31], rs_reg};
    assign mb = {(mode_reg == OP_MULT) & rt_reg[31], rt_reg};

    // divider step
    logic [32:0] trial;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status;
            npc_reg    <= npc;
            we_reg     <= we;
            widx_reg   <= we ? widx : '0;
            wval_reg   <= we ? r : '0;
            prod_reg   <= 64'(ma * mb);
            cnt_reg    <= '0;
            rem_reg    <= '0;
            neg_q_reg  <= (mode_reg == OP_DIV) && (rs_reg[31] ^ rt_reg[31]);
            neg_r_reg  <= (mode_reg == OP_DIV) && rs_reg[31];
            quo_reg    <= ((mode_reg == OP_DIV) && rs_reg[31]) ? -rs_reg : rs_reg;
            divisor_reg <= ((mode_reg == OP_DIV) && rt_reg[31]) ? -rt_reg : rt_reg;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (!trial[32]) begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    // HI/LO
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg <= '0;
            lo_reg <= '0;
        end else if (cmd.exec && mode_reg == OP_MTHI) begin
            hi_reg <= rs_reg;
        end else if (cmd.exec && mode_reg == OP_MTLO) begin
            lo_reg <= rs_reg;
        end else if (cmd.mul_fin) begin
            hi_reg <= prod_reg[63:32];
            lo_reg <= prod_reg[31:0];
        end else if (cmd.div_fin) begin
            hi_reg <= neg_r_reg ? -rem_reg : rem_reg;
            lo_reg <= neg_q_reg ? -quo_reg : quo_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_status  <= status_reg;
            out_next_pc <= npc_reg;
            out_we      <= we_reg;
            out_widx    <= widx_reg;
            out_wval    <= wval_reg;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/mips_integer_execute_unit.sv
// MIPS32 integer execute unit, top level: stream ports, controller, datapath.
// Depends on miu_pkg, miu_ctrl and miu_dp.
//
// Usage: one decoded instruction enters per s_ beat; exactly one result beat
// leaves on m_ for each. The cfg channel writes the text_base register; it
// does not move the running program counter. Write it only while idle.
// Flow: most operations go through the read, execute and done states to the
// result beat; mult/multu add a state for the registered 33x33 product and
// div/divu with a nonzero divisor add 32 steps of the radix-2 restoring
// divider. One instruction is in flight at a time, so a new input beat is
// taken only after the result beat has been taken and the unit is idle again.
// Reset clears the register file, HI and LO and sets pc to 0x00400000.
// When the receiver stalls, the result holds in the output register and
// s_tready stays low until the result beat is taken.
`default_nettype none
module mips_integer_execute_unit
    import miu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [5:0] mode, [10:6] rs_index, [15:11] rt_index, [20:16] rd_index,
    // [36:21] immediate, [41:37] shift_amount, [67:42] jump_target, zero pad
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [33:2] next_pc, [34] write_enable, [39:35] write_index,
    // [71:40] write_value
    output logic [71:0]      m_tdata
);
    cmd_t  cmd;
    stat_t st;
    logic  in_beat, out_beat;
    logic [1:0]  o_status;
    logic [31:0] o_npc, o_wval;
    logic        o_we;
    logic [4:0]  o_widx;

    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid & s_tready;
    assign out_beat  = m_tvalid & m_tready;
    assign m_tdata   = {o_wval, o_widx, o_we, o_npc, o_status};

    miu_ctrl u_ctrl (
        .aclk, .aresetn, .in_beat, .out_beat, .st, .cmd,
        .in_ready(s_tready), .out_valid(m_tvalid)
    );

    miu_dp u_dp (
        .aclk, .aresetn, .cmd, .st,
        .cfg_beat(cfg_valid & cfg_ready), .cfg_data,
        .in_mode(s_tdata[5:0]), .in_rs(s_tdata[10:6]), .in_rt(s_tdata[15:11]),
        .in_rd(s_tdata[20:16]), .in_imm(s_tdata[36:21]),
        .in_shamt(s_tdata[41:37]), .in_target(s_tdata[67:42]),
        .out_status(o_status), .out_next_pc(o_npc), .out_we(o_we),
        .out_widx(o_widx), .out_wval(o_wval)
    );

    // one instruction in flight: never ready for input while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    // a write to register zero is never reported
    a_r0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tdata[39:35] != 5'd0)
        else $error("write to register zero reported");
    // no result is offered while the instruction is still being read and executed
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
        else $error("result too early");
endmodule
`default_nettype wire
